// ===== sv/pwb_pkg.sv =====
// ----------------------------------------------------------------------------
// pwb_pkg
// shared widths, register indexes and the walk position type for the
// blocked 1x1 weight packing address generator
// ----------------------------------------------------------------------------
package pwb_pkg;

    // channel counts and positions
    localparam int CH_W   = 13;
    // channel sums that may pass the largest count
    localparam int EXT_W  = CH_W + 1;
    // largest value a channel register can hold
    localparam int CH_MAX = (2 ** CH_W) - 1;
    // lane within a group, groups hold at most 64 lanes
    localparam int LANE_W = 6;
    // source and destination index width
    localparam int IDX_W  = 24;
    // configuration index width
    localparam int CFG_W  = 1;

    // configuration register indexes
    localparam logic [CFG_W-1:0] REG_OUT_CHANNELS = 1'd0;
    localparam logic [CFG_W-1:0] REG_IN_CHANNELS  = 1'd1;

    // position of the walk through the blocked order
    typedef struct packed {
        logic [CH_W-1:0]   in_block_base;
        logic [CH_W-1:0]   out_block_base;
        logic [CH_W-1:0]   group_base;
        logic [CH_W-1:0]   channel_pos;
        logic [LANE_W-1:0] lane_pos;
    } pwb_pos_t;

endpackage

// ===== sv/pack_weights_1x1_blocked_top.sv =====
// ----------------------------------------------------------------------------
// pack_weights_1x1_blocked_top
// address generator for repacking 1x1 convolution weights into blocked order
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one request per element; s_tdata[0] is restart. A request
//   with restart set begins a new pass at element zero using the channel
//   counts on the cfg channel, a request with restart clear steps the pass.
//   m_* channel: one result per request. m_tdata holds source and destination
//   index, m_tlast marks the final element, m_tuser[0] is set when the
//   result holds an element (clear when no pass is running).
//   cfg channel: writes the output and input channel counts; always ready.
//   Counts are latched at restart, so a write takes effect at the next pass.
// Timing:
//   the result of a request is registered and appears in the cycle after it is taken; one request per
//   cycle sustained while m_tready is high. The whole step (walk carry chain plus one 13x13 multiply
//   for the source index) sits between the position registers and the result register.
// Reset:
//   no pass running, both channel counts 1, no result held.
// Stall:
//   while m_tready is low the result register holds and s_tready drops once
//   it is full; a request is taken in the same cycle a result leaves.
// ----------------------------------------------------------------------------
module pack_weights_1x1_blocked_top #(
    parameter int MAX_CHANNELS = 4096,
    parameter int OUT_BLOCK    = 64,
    parameter int IN_BLOCK     = 128,
    parameter int GROUP_SIZE   = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // [0] restart, [7:1] zero
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*pwb_pkg::IDX_W-1:0]   m_tdata,    // [23:0] source_index, [47:24] dest_index
    output logic                          m_tlast,
    output logic [0:0]                    m_tuser,    // [0] valid_res
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pwb_pkg::CFG_W-1:0]     cfg_index,
    input  logic [pwb_pkg::CH_W-1:0]      cfg_data
);

    localparam int MAX_CLIP = (MAX_CHANNELS > pwb_pkg::CH_MAX) ? pwb_pkg::CH_MAX : MAX_CHANNELS;
    localparam logic [pwb_pkg::CH_W-1:0] CLIP = pwb_pkg::CH_W'(MAX_CLIP);

    logic [pwb_pkg::CH_W-1:0]  out_channels_reg;
    logic [pwb_pkg::CH_W-1:0]  in_channels_reg;
    logic [pwb_pkg::CH_W-1:0]  pass_out_reg;
    logic [pwb_pkg::CH_W-1:0]  pass_in_reg;
    logic [pwb_pkg::CH_W-1:0]  pass_out_next;
    logic [pwb_pkg::CH_W-1:0]  pass_in_next;
    pwb_pkg::pwb_pos_t         pos_reg;
    pwb_pkg::pwb_pos_t         pos_cur;
    pwb_pkg::pwb_pos_t         pos_walk;
    pwb_pkg::pwb_pos_t         pos_next;
    logic [pwb_pkg::IDX_W-1:0] write_pos_reg;
    logic [pwb_pkg::IDX_W-1:0] write_cur;
    logic                      running_reg;
    logic                      running_cur;
    logic                      running_next;
    logic                      more;
    logic                      restart;
    logic                      accept;
    logic [pwb_pkg::CH_W-1:0]  row;
    logic [2*pwb_pkg::CH_W-1:0] src_full;

    logic                      out_valid_reg;
    logic [pwb_pkg::IDX_W-1:0] src_reg;
    logic [pwb_pkg::IDX_W-1:0] dst_reg;
    logic                      last_reg;
    logic                      valid_res_reg;

    // handshakes
    assign restart   = s_tdata[0];
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_channels_reg <= pwb_pkg::CH_W'(1);
            in_channels_reg  <= pwb_pkg::CH_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pwb_pkg::REG_OUT_CHANNELS: out_channels_reg <= cfg_data;
                pwb_pkg::REG_IN_CHANNELS:  in_channels_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // restart selects a fresh pass with clipped counts
    always_comb
    begin
        if (restart)
        begin
            pass_out_next = (out_channels_reg > CLIP) ? CLIP : out_channels_reg;
            pass_in_next  = (in_channels_reg > CLIP) ? CLIP : in_channels_reg;
            pos_cur       = '0;
            write_cur     = '0;
            running_cur   = (pass_out_next != '0) && (pass_in_next != '0);
        end
        else
        begin
            pass_out_next = pass_out_reg;
            pass_in_next  = pass_in_reg;
            pos_cur       = pos_reg;
            write_cur     = write_pos_reg;
            running_cur   = running_reg;
        end
    end

    pwb_walk #(
        .OUT_BLOCK  (OUT_BLOCK),
        .IN_BLOCK   (IN_BLOCK),
        .GROUP_SIZE (GROUP_SIZE)
    ) u_walk (
        .pos      (pos_cur),
        .pass_out (pass_out_next),
        .pass_in  (pass_in_next),
        .pos_next (pos_walk),
        .more     (more)
    );

    // hold position when idle
    always_comb
    begin
        pos_next     = running_cur ? pos_walk : pos_cur;
        running_next = running_cur && more;
    end

    // source index: (group_base + lane) * in_channels + channel
    always_comb
    begin
        row      = pos_cur.group_base + pwb_pkg::CH_W'(pos_cur.lane_pos);
        src_full = (2*pwb_pkg::CH_W)'(row) * (2*pwb_pkg::CH_W)'(pass_in_next)
                   + (2*pwb_pkg::CH_W)'(pos_cur.channel_pos);
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_out_reg  <= '0;
            pass_in_reg   <= '0;
            pos_reg       <= '0;
            write_pos_reg <= '0;
            running_reg   <= 1'b0;
        end
        else if (accept)
        begin
            pass_out_reg  <= pass_out_next;
            pass_in_reg   <= pass_in_next;
            pos_reg       <= pos_next;
            write_pos_reg <= running_cur ? (write_cur + pwb_pkg::IDX_W'(1)) : write_cur;
            running_reg   <= running_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg       <= running_cur ? src_full[pwb_pkg::IDX_W-1:0] : '0;
            dst_reg       <= running_cur ? write_cur : '0;
            last_reg      <= running_cur && !more;
            valid_res_reg <= running_cur;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {dst_reg, src_reg};
    assign m_tlast    = last_reg;
    assign m_tuser[0] = valid_res_reg;

    // last only on a real element
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("last set on an idle result");

    // idle results carry zero indexes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("idle result with nonzero indexes");

    // a step with no pass running gives an idle result
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !restart && !running_reg |=> m_tvalid && !m_tuser[0])
        else $error("element produced without a running pass");

    // lane stays inside its group
    assert property (@(posedge clk) disable iff (!rst_n)
        pwb_pkg::EXT_W'(pos_reg.lane_pos) < pwb_pkg::EXT_W'(GROUP_SIZE))
        else $error("lane position beyond group size");

endmodule

// ===== sv/pwb_walk.sv =====
// ----------------------------------------------------------------------------
// pwb_walk
// next position of the blocked walk: lane, then input channel, then group,
// then output block, then input block
// ----------------------------------------------------------------------------
module pwb_walk #(
    parameter int OUT_BLOCK  = 64,
    parameter int IN_BLOCK   = 128,
    parameter int GROUP_SIZE = 12
) (
    input  pwb_pkg::pwb_pos_t              pos,
    input  logic [pwb_pkg::CH_W-1:0]       pass_out,
    input  logic [pwb_pkg::CH_W-1:0]       pass_in,
    output pwb_pkg::pwb_pos_t              pos_next,
    output logic                           more
);

    localparam logic [pwb_pkg::EXT_W-1:0] OB = pwb_pkg::EXT_W'(OUT_BLOCK);
    localparam logic [pwb_pkg::EXT_W-1:0] IB = pwb_pkg::EXT_W'(IN_BLOCK);
    localparam logic [pwb_pkg::EXT_W-1:0] GS = pwb_pkg::EXT_W'(GROUP_SIZE);

    logic [pwb_pkg::EXT_W-1:0] po_x;
    logic [pwb_pkg::EXT_W-1:0] pi_x;
    logic [pwb_pkg::EXT_W-1:0] blk_rem;
    logic [pwb_pkg::EXT_W-1:0] blk_end;
    logic [pwb_pkg::EXT_W-1:0] grp_span;
    logic [pwb_pkg::EXT_W-1:0] grp_len;
    logic [pwb_pkg::EXT_W-1:0] in_end_raw;
    logic [pwb_pkg::EXT_W-1:0] in_end;
    logic [pwb_pkg::EXT_W-1:0] lane_inc;
    logic [pwb_pkg::EXT_W-1:0] chan_inc;
    logic [pwb_pkg::EXT_W-1:0] group_inc;

    // block and group extents at the current position
    always_comb
    begin
        po_x       = {1'b0, pass_out};
        pi_x       = {1'b0, pass_in};
        blk_rem    = po_x - {1'b0, pos.out_block_base};
        blk_end    = {1'b0, pos.out_block_base} + ((blk_rem < OB) ? blk_rem : OB);
        grp_span   = blk_end - {1'b0, pos.group_base};
        grp_len    = (grp_span < GS) ? grp_span : GS;
        in_end_raw = {1'b0, pos.in_block_base} + IB;
        in_end     = (in_end_raw < pi_x) ? in_end_raw : pi_x;
        lane_inc   = pwb_pkg::EXT_W'(pos.lane_pos) + pwb_pkg::EXT_W'(1);
        chan_inc   = {1'b0, pos.channel_pos} + pwb_pkg::EXT_W'(1);
        group_inc  = {1'b0, pos.group_base} + grp_len;
    end

    // carry through the nested counters
    always_comb
    begin
        pos_next = pos;
        more     = 1'b1;
        if (lane_inc < grp_len)
        begin
            pos_next.lane_pos = lane_inc[pwb_pkg::LANE_W-1:0];
        end
        else
        begin
            pos_next.lane_pos = '0;
            if (chan_inc < in_end)
            begin
                pos_next.channel_pos = chan_inc[pwb_pkg::CH_W-1:0];
            end
            else
            begin
                pos_next.channel_pos = pos.in_block_base;
                if (group_inc < blk_end)
                begin
                    pos_next.group_base = group_inc[pwb_pkg::CH_W-1:0];
                end
                else if (blk_end < po_x)
                begin
                    pos_next.out_block_base = blk_end[pwb_pkg::CH_W-1:0];
                    pos_next.group_base     = blk_end[pwb_pkg::CH_W-1:0];
                end
                else
                begin
                    pos_next.out_block_base = '0;
                    pos_next.group_base     = '0;
                    if (in_end < pi_x)
                    begin
                        pos_next.in_block_base = in_end[pwb_pkg::CH_W-1:0];
                        pos_next.channel_pos   = in_end[pwb_pkg::CH_W-1:0];
                    end
                    else
                    begin
                        pos_next.in_block_base = '0;
                        pos_next.channel_pos   = '0;
                        more                   = 1'b0;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/pwb_addr_checker.sv =====
// ----------------------------------------------------------------------------
// pwb_addr_checker
// watches the request, result and configuration channels of the blocked 1x1
// weight packing address generator, predicts each address pair from its own
// copy of the walk and compares every result field against the oldest one
// ----------------------------------------------------------------------------
module pwb_addr_checker #(
    parameter int MAX_CHANNELS = 4096,
    parameter int OUT_BLOCK    = 64,
    parameter int IN_BLOCK     = 128,
    parameter int GROUP_SIZE   = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // [0] restart, [7:1] zero
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [2*pwb_pkg::IDX_W-1:0]   m_tdata,    // [23:0] source_index, [47:24] dest_index
    input  logic                          m_tlast,
    input  logic [0:0]                    m_tuser,    // [0] valid_res
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pwb_pkg::CFG_W-1:0]     cfg_index,
    input  logic [pwb_pkg::CH_W-1:0]      cfg_data,
    output int                            pending,
    output int                            errors
);

    // one predicted address pair
    typedef struct packed {
        logic [pwb_pkg::IDX_W-1:0] src;
        logic [pwb_pkg::IDX_W-1:0] dst;
        logic                      last;
        logic                      live;
    } addr_pair_t;

    addr_pair_t expected_pairs[$];
    int         fail_cnt = 0;

    // channel count registers as written
    logic [pwb_pkg::CH_W-1:0]   reg_out;
    logic [pwb_pkg::CH_W-1:0]   reg_in;
    // counts latched for the running pass
    logic [pwb_pkg::CH_W-1:0]   lat_out;
    logic [pwb_pkg::CH_W-1:0]   lat_in;
    // walk position
    logic [pwb_pkg::CH_W-1:0]   in_blk;
    logic [pwb_pkg::CH_W-1:0]   out_blk;
    logic [pwb_pkg::CH_W-1:0]   grp_start;
    logic [pwb_pkg::CH_W-1:0]   chan;
    logic [pwb_pkg::LANE_W-1:0] lane;
    logic [pwb_pkg::IDX_W-1:0]  wr_ptr;
    logic                       walking;

    assign errors = fail_cnt;

    // counts above the supported maximum are treated as the maximum
    function automatic logic [pwb_pkg::CH_W-1:0] limit_count(input logic [pwb_pkg::CH_W-1:0] v);
        return (v > MAX_CHANNELS) ? pwb_pkg::CH_W'(MAX_CHANNELS) : v;
    endfunction

    // step to the next element of the blocked order, 0 once the pass is done
    function automatic bit walk_advance();
        int unsigned blk_end;
        int unsigned grp_len;
        int unsigned in_end;
        int unsigned out_left;
        int unsigned grp_left;
        out_left = lat_out - out_blk;
        blk_end  = out_blk + ((out_left < OUT_BLOCK) ? out_left : OUT_BLOCK);
        grp_left = blk_end - grp_start;
        grp_len  = (grp_left < GROUP_SIZE) ? grp_left : GROUP_SIZE;
        in_end   = ((in_blk + IN_BLOCK) < lat_in) ? (in_blk + IN_BLOCK) : lat_in;

        // next lane of the group, compared before narrowing to the lane width
        if (lane + 1 < grp_len)
        begin
            lane = lane + 1'b1;
            return 1'b1;
        end
        lane = '0;
        // next input channel of the block
        chan = chan + 1'b1;
        if (chan < in_end)
            return 1'b1;
        chan = in_blk;
        // next group of the output block
        grp_start = grp_start + grp_len;
        if (grp_start < blk_end)
            return 1'b1;
        // next output block
        out_blk   = blk_end;
        grp_start = out_blk;
        if (out_blk < lat_out)
            return 1'b1;
        // next input block
        out_blk   = '0;
        grp_start = '0;
        in_blk    = in_end;
        chan      = in_blk;
        if (in_blk < lat_in)
            return 1'b1;
        in_blk = '0;
        chan   = '0;
        return 1'b0;
    endfunction

    // address pair caused by one request
    function automatic addr_pair_t predict_pair(input logic restart);
        addr_pair_t  p;
        int unsigned row;
        logic [63:0] src;
        p = '0;
        if (restart)
        begin
            lat_out   = limit_count(reg_out);
            lat_in    = limit_count(reg_in);
            in_blk    = '0;
            out_blk   = '0;
            grp_start = '0;
            chan      = '0;
            lane      = '0;
            wr_ptr    = '0;
            walking   = (lat_out != 0) && (lat_in != 0);
        end
        if (walking)
        begin
            row     = grp_start + lane;
            src     = 64'(row) * 64'(lat_in) + 64'(chan);
            p.src   = src[pwb_pkg::IDX_W-1:0];
            p.dst   = wr_ptr;
            wr_ptr  = wr_ptr + 1'b1;
            walking = walk_advance();
            p.last  = !walking;
            p.live  = 1'b1;
        end
        return p;
    endfunction

    // report one field that differs
    task automatic compare_field(input string what, input logic [pwb_pkg::IDX_W-1:0] want,
                                 input logic [pwb_pkg::IDX_W-1:0] got);
        if (want !== got)
        begin
            if (fail_cnt < 40)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            fail_cnt++;
        end
    endtask

    // track writes and requests, check results
    always @(posedge clk or negedge rst_n)
    begin : track
        addr_pair_t want;
        if (!rst_n)
        begin
            expected_pairs.delete();
            reg_out   = pwb_pkg::CH_W'(1);
            reg_in    = pwb_pkg::CH_W'(1);
            lat_out   = '0;
            lat_in    = '0;
            in_blk    = '0;
            out_blk   = '0;
            grp_start = '0;
            chan      = '0;
            lane      = '0;
            wr_ptr    = '0;
            walking   = 1'b0;
            pending  <= 0;
        end
        else
        begin
            // result leaving the block
            if (m_tvalid && m_tready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    if (fail_cnt < 40)
                        $display("%0t: result with no request, expected none, actual %h",
                                 $time, m_tdata);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    compare_field("source_index", want.src, m_tdata[pwb_pkg::IDX_W-1:0]);
                    compare_field("dest_index", want.dst,
                                  m_tdata[2*pwb_pkg::IDX_W-1:pwb_pkg::IDX_W]);
                    compare_field("last", pwb_pkg::IDX_W'(want.last), pwb_pkg::IDX_W'(m_tlast));
                    compare_field("valid_res", pwb_pkg::IDX_W'(want.live),
                                  pwb_pkg::IDX_W'(m_tuser[0]));
                end
            end
            // register write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == pwb_pkg::REG_OUT_CHANNELS)
                    reg_out = cfg_data;
                else if (cfg_index == pwb_pkg::REG_IN_CHANNELS)
                    reg_in = cfg_data;
            end
            // request entering the block
            if (s_tvalid && s_tready)
                expected_pairs.push_back(predict_pair(s_tdata[0]));
            pending <= expected_pairs.size();
        end
    end

endmodule

// ===== sim/pack_weights_1x1_blocked_top_test.sv =====
// ----------------------------------------------------------------------------
// pack_weights_1x1_blocked_top_test
// drives restart and step requests and channel count writes into the blocked
// weight packing address generator, with random gaps and result stalls; a
// checker beside the block predicts and compares every address pair
// ----------------------------------------------------------------------------
module pack_weights_1x1_blocked_top_test;

    localparam int MAX_CH       = 4096;
    localparam int OUT_BLK      = 64;
    localparam int IN_BLK       = 128;
    localparam int GRP          = 12;
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_ITEMS   = 120;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic [7:0]                    s_tdata   = '0;
    logic                          m_tready  = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [pwb_pkg::CFG_W-1:0]     cfg_index = '0;
    logic [pwb_pkg::CH_W-1:0]      cfg_data  = '0;
    logic                          s_tready;
    logic                          m_tvalid;
    logic [2*pwb_pkg::IDX_W-1:0]   m_tdata;
    logic                          m_tlast;
    logic [0:0]                    m_tuser;
    logic                          cfg_ready;

    int pending;
    int errors;
    int sent     = 0;
    int pass_len = 1;
    int gap_pct  = 0;
    int quiet    = 0;
    bit calm     = 1'b0;

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pack_weights_1x1_blocked_top #(
        .MAX_CHANNELS (MAX_CH),
        .OUT_BLOCK    (OUT_BLK),
        .IN_BLOCK     (IN_BLK),
        .GROUP_SIZE   (GRP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pwb_addr_checker #(
        .MAX_CHANNELS (MAX_CH),
        .OUT_BLOCK    (OUT_BLK),
        .IN_BLOCK     (IN_BLK),
        .GROUP_SIZE   (GRP)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side stalls in bursts, none near the end
    initial
    begin
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    // one request, with an optional idle burst ahead of it
    task automatic send_req(input bit restart);
        if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // stop requesting and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // write both channel counts, block must be idle
    task automatic set_counts(input logic [pwb_pkg::CH_W-1:0] n_out,
                              input logic [pwb_pkg::CH_W-1:0] n_in);
        int eff_out;
        int eff_in;
        cfg_valid <= 1'b1;
        cfg_index <= pwb_pkg::REG_OUT_CHANNELS;
        cfg_data  <= n_out;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= pwb_pkg::REG_IN_CHANNELS;
        cfg_data  <= n_in;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        eff_out  = (n_out > MAX_CH) ? MAX_CH : n_out;
        eff_in   = (n_in > MAX_CH) ? MAX_CH : n_in;
        pass_len = eff_out * eff_in;
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int                       base;
        int                       budget;
        int                       steps;
        int                       burst;
        logic [pwb_pkg::CH_W-1:0] n_out;
        logic [pwb_pkg::CH_W-1:0] n_in;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset counts: idle step, single element pass, idle after the end
        gap_pct = 20;
        send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);
        // zero output channels gives an empty pass
        drain();
        set_counts(pwb_pkg::CH_W'(0), pwb_pkg::CH_W'(5));
        send_req(1'b1);
        send_req(1'b0);
        // zero input channels
        drain();
        set_counts(pwb_pkg::CH_W'(3), pwb_pkg::CH_W'(0));
        send_req(1'b1);
        // oversized counts clamp to the maximum
        drain();
        set_counts('1, '1);
        send_req(1'b1);
        repeat (3) send_req(1'b0);
        // write lands mid-pass, old counts stay until restart
        drain();
        set_counts(pwb_pkg::CH_W'(2), pwb_pkg::CH_W'(2));
        repeat (3) send_req(1'b0);
        send_req(1'b1);
        repeat (4) send_req(1'b0);
        // largest legal counts
        drain();
        set_counts(pwb_pkg::CH_W'(MAX_CH), pwb_pkg::CH_W'(MAX_CH));
        send_req(1'b1);
        repeat (2) send_req(1'b0);

        // random phases, each with its own channel counts
        base = sent;
        while (sent - base < RANDOM_ITEMS)
        begin
            drain();
            calm = (sent - base) >= (RANDOM_ITEMS - CALM_ITEMS);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 10;
                default: gap_pct = 35;
            endcase
            case ($urandom_range(0, 9))
                0:
                begin
                    // input channel counts around the input block size, often crossing it
                    n_out = pwb_pkg::CH_W'($urandom_range(1, 3));
                    n_in  = pwb_pkg::CH_W'($urandom_range(IN_BLK - 8, IN_BLK + 12));
                end
                1:
                begin
                    // output channel counts around the output block size, often crossing it
                    n_out = pwb_pkg::CH_W'($urandom_range(OUT_BLK - 4, OUT_BLK + 16));
                    n_in  = pwb_pkg::CH_W'($urandom_range(1, 2));
                end
                2:
                begin
                    n_out = pwb_pkg::CH_W'($urandom_range(0, 1) * $urandom_range(1, 20));
                    n_in  = (n_out == 0) ? pwb_pkg::CH_W'($urandom_range(0, 9))
                                         : pwb_pkg::CH_W'(0);
                end
                3:
                begin
                    n_out = pwb_pkg::CH_W'($urandom_range(MAX_CH + 1, (2 ** pwb_pkg::CH_W) - 1));
                    n_in  = pwb_pkg::CH_W'($urandom_range(1, 3));
                end
                default:
                begin
                    n_out = pwb_pkg::CH_W'($urandom_range(1, 30));
                    n_in  = pwb_pkg::CH_W'($urandom_range(1, 8));
                end
            endcase
            set_counts(n_out, n_in);

            budget = $urandom_range(50, 110);
            if (pass_len <= 450 && pass_len > budget)
                budget = pass_len + $urandom_range(1, 10);
            // keep the random section near its item count
            if (budget > RANDOM_ITEMS - (sent - base))
                budget = RANDOM_ITEMS - (sent - base);
            while (budget > 0)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    // whole pass, sometimes cut short, a few idle steps past the end
                    steps = pass_len - 1 + $urandom_range(0, 2);
                    if (steps > budget - 1)
                        steps = budget - 1;
                    if (steps < 0)
                        steps = 0;
                    send_req(1'b1);
                    repeat (steps) send_req(1'b0);
                    budget -= steps + 1;
                end
                else
                begin
                    // random restart and step mix
                    burst = $urandom_range(1, 6);
                    repeat (burst) send_req($urandom_range(0, 1) == 1);
                    budget -= burst;
                end
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
